[hdl/cmdf_pkg.sv]
// ----------------------------------------------------------------------------
// cmdf_pkg
// Types and constants shared by the control message deframer modules.
// ----------------------------------------------------------------------------
package cmdf_pkg;

   localparam int unsigned SESSION_W = 4;

   localparam logic [31:0] RESET_MAX_LENGTH = 32'd1048576;
   localparam logic [31:0] MIN_LENGTH       = 32'd2;
   localparam logic [2:0]  HDR_BYTES        = 3'd6;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DISCARD = 2'd2
   } phase_type;

   // per-session context entry
   typedef struct packed {
      phase_type   phase;
      logic [2:0]  hdr_count;
      logic [31:0] length_acc;
      logic [15:0] type_acc;
      logic [31:0] bytes_left;
   } ctx_type;

   localparam ctx_type CTX_RESET = '{
      phase:      PH_HEADER,
      hdr_count:  3'd0,
      length_acc: 32'd0,
      type_acc:   16'd0,
      bytes_left: 32'd0
   };

   typedef struct packed {
      logic [SESSION_W-1:0] out_session;
      logic [15:0]          msg_code;
      logic [7:0]           payload_byte;
      logic                 has_data;
      logic                 first;
      logic                 last;
      logic                 error;
   } rsp_type;

   // register addresses (byte address bit 2 selects the word)
   localparam logic REG_MAX_LENGTH = 1'b0;

endpackage

[hdl/cmdf_ram.sv]
// ----------------------------------------------------------------------------
// cmdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cmdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/cmdf_csr.sv]
// ----------------------------------------------------------------------------
// cmdf_csr
// Configuration register file: holds the largest accepted length field.
// ----------------------------------------------------------------------------
module cmdf_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [31:0] max_length
);

   logic [31:0] max_length_ff;
   logic [31:0] max_length_in;
   logic        wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == cmdf_pkg::REG_MAX_LENGTH);

   always_comb begin
      max_length_in = max_length_ff;
      if (wr_hit) begin
         max_length_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= cmdf_pkg::RESET_MAX_LENGTH;
      end else begin
         max_length_ff <= max_length_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         cmdf_pkg::REG_MAX_LENGTH: prdata = max_length_ff;
         default:                  prdata = 32'd0;
      endcase
   end

   assign max_length = max_length_ff;

endmodule

[hdl/cmdf_ctx_update.sv]
// ----------------------------------------------------------------------------
// cmdf_ctx_update
// Modify step of the context read-modify-write: header assembly, length
// check, payload tagging and discard handling for one byte.
// ----------------------------------------------------------------------------
module cmdf_ctx_update (
   input  cmdf_pkg::ctx_type                   cur,
   input  logic [cmdf_pkg::SESSION_W-1:0]      session,
   input  logic [7:0]                          data_byte,
   input  logic                                chunk_end,
   input  logic [31:0]                         max_length,
   output cmdf_pkg::ctx_type                   nxt,
   output cmdf_pkg::rsp_type                   rsp,
   output logic                                rsp_en
);

   logic [2:0]  cnt;
   logic [2:0]  cnt_inc;
   logic [31:0] len_new;
   logic [15:0] type_new;
   logic        pay_first;
   logic        pay_last;

   always_comb begin
      cnt = (cur.hdr_count >= cmdf_pkg::HDR_BYTES) ? 3'd0 : cur.hdr_count;
      cnt_inc = cnt + 3'd1;
      len_new = cur.length_acc;
      type_new = cur.type_acc;
      if (cnt < 3'd4) begin
         len_new = cur.length_acc | (32'(data_byte) << {cnt[1:0], 3'b000});
      end else begin
         type_new = cur.type_acc | (16'(data_byte) << {cnt[0], 3'b000});
      end
      pay_first = (cur.bytes_left == (cur.length_acc - cmdf_pkg::MIN_LENGTH));
      pay_last = (cur.bytes_left <= 32'd1);
   end

   always_comb begin
      nxt = cur;
      rsp_en = 1'b0;
      rsp = '0;
      rsp.out_session = session;
      rsp.msg_code = cur.type_acc;
      unique case (cur.phase)
         cmdf_pkg::PH_DISCARD: begin
            if (chunk_end) begin
               nxt = cmdf_pkg::CTX_RESET;
            end
         end
         cmdf_pkg::PH_PAYLOAD: begin
            rsp_en = 1'b1;
            rsp.payload_byte = data_byte;
            rsp.has_data = 1'b1;
            rsp.first = pay_first;
            rsp.last = pay_last;
            if (pay_last) begin
               nxt = cmdf_pkg::CTX_RESET;
            end else begin
               nxt.bytes_left = cur.bytes_left - 32'd1;
            end
         end
         default: begin
            rsp.msg_code = type_new;
            if (cnt_inc < cmdf_pkg::HDR_BYTES) begin
               nxt.phase = cmdf_pkg::PH_HEADER;
               nxt.hdr_count = cnt_inc;
               nxt.length_acc = len_new;
               nxt.type_acc = type_new;
            end else if ((len_new < cmdf_pkg::MIN_LENGTH) || (len_new > max_length)) begin
               rsp_en = 1'b1;
               rsp.error = 1'b1;
               nxt = cmdf_pkg::CTX_RESET;
               if (!chunk_end) begin
                  nxt.phase = cmdf_pkg::PH_DISCARD;
               end
            end else if (len_new == cmdf_pkg::MIN_LENGTH) begin
               rsp_en = 1'b1;
               rsp.first = 1'b1;
               rsp.last = 1'b1;
               nxt = cmdf_pkg::CTX_RESET;
            end else begin
               nxt.phase = cmdf_pkg::PH_PAYLOAD;
               nxt.hdr_count = cnt_inc;
               nxt.length_acc = len_new;
               nxt.type_acc = type_new;
               nxt.bytes_left = len_new - cmdf_pkg::MIN_LENGTH;
            end
         end
      endcase
   end

endmodule

[hdl/control_message_deframer_core.sv]
// ----------------------------------------------------------------------------
// control_message_deframer_core
// Per-session deframer for [len32 LE][type16 LE][payload] byte streams.
// Path: the accepting edge loads the s1 registers and reads the context RAM;
// the update then loads the rsp register, unless a stalled result holds it.
// Throughput: one item per cycle while no result waits on rsp_stall; the context
// RAM read-modify-write with a one-entry forwarding register keeps back-to-back bytes of one session going.
// req_stall is high only while a result waits behind a stalled rsp register.
// Reset: valid bits clear every context; max_length = 1048576.
// ----------------------------------------------------------------------------
module control_message_deframer_core #(
   parameter int SESSIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_session,
   input  logic [7:0]  req_data_byte,
   input  logic        req_chunk_end,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_out_session,
   output logic [15:0] rsp_msg_code,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_has_data,
   output logic        rsp_first,
   output logic        rsp_last,
   output logic        rsp_error,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int DEPTH = (SESSIONS < 16) ? SESSIONS : 16;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $bits(cmdf_pkg::ctx_type);

   logic [31:0] max_length;

   logic          req_accept;
   logic          in_range;
   logic [AW-1:0] req_addr;

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_hit_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [3:0]    s1_session_ff;
   logic [7:0]    s1_byte_ff;
   logic          s1_cend_ff;
   logic          s1_ent_valid_ff;
   logic          s1_go;

   logic [DEPTH-1:0] vld_ff, vld_in;

   logic              fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0]     fwd_addr_ff;
   cmdf_pkg::ctx_type fwd_data_ff;

   logic [CW-1:0]     ram_q;
   cmdf_pkg::ctx_type cur;
   cmdf_pkg::ctx_type nxt;
   cmdf_pkg::rsp_type upd_rsp;
   logic              upd_rsp_en;
   logic              ctx_wr;
   logic              rsp_push;

   logic              rsp_valid_ff, rsp_valid_in;
   cmdf_pkg::rsp_type rsp_ff;

   cmdf_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .max_length (max_length)
   );

   assign in_range   = ({28'd0, req_session} < 32'(SESSIONS));
   assign req_addr   = req_session[AW-1:0];
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;

   cmdf_ram #(
      .WIDTH (CW),
      .DEPTH (DEPTH)
   ) u_ctx_ram (
      .clock   (clock),
      .wr_en   (ctx_wr),
      .wr_addr (s1_addr_ff),
      .wr_data (nxt),
      .rd_en   (req_accept && in_range),
      .rd_addr (req_addr),
      .rd_data (ram_q)
   );

   // newest write to the same entry wins over the RAM read data
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         cur = fwd_data_ff;
      end else if (s1_ent_valid_ff) begin
         cur = cmdf_pkg::ctx_type'(ram_q);
      end else begin
         cur = cmdf_pkg::CTX_RESET;
      end
   end

   cmdf_ctx_update u_update (
      .cur        (cur),
      .session    (s1_session_ff),
      .data_byte  (s1_byte_ff),
      .chunk_end  (s1_cend_ff),
      .max_length (max_length),
      .nxt        (nxt),
      .rsp        (upd_rsp),
      .rsp_en     (upd_rsp_en)
   );

   always_comb begin
      s1_go = !(s1_hit_ff && upd_rsp_en) || !rsp_valid_ff || !rsp_stall;
      ctx_wr = s1_valid_ff && s1_hit_ff && s1_go;
      rsp_push = ctx_wr && upd_rsp_en;
      s1_valid_in = req_accept || (s1_valid_ff && !s1_go);
      vld_in = vld_ff;
      if (ctx_wr) begin
         vld_in[s1_addr_ff] = 1'b1;
      end
      fwd_valid_in = fwd_valid_ff || ctx_wr;
      if (rsp_push) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         vld_ff       <= '0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         vld_ff       <= vld_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_hit_ff       <= in_range;
         s1_addr_ff      <= req_addr;
         s1_session_ff   <= req_session;
         s1_byte_ff      <= req_data_byte;
         s1_cend_ff      <= req_chunk_end;
         s1_ent_valid_ff <= in_range && vld_ff[req_addr];
      end
      if (ctx_wr) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= nxt;
      end
      if (rsp_push) begin
         rsp_ff <= upd_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_session  = rsp_ff.out_session;
   assign rsp_msg_code     = rsp_ff.msg_code;
   assign rsp_payload_byte = rsp_ff.payload_byte;
   assign rsp_has_data     = rsp_ff.has_data;
   assign rsp_first        = rsp_ff.first;
   assign rsp_last         = rsp_ff.last;
   assign rsp_error        = rsp_ff.error;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for control_message_deframer_core. A small tracker
// predicts every result from the accepted byte stream and checks the results
// in order. A short directed sequence is followed by random well-formed and
// malformed messages interleaved across all sessions, under several
// max_length settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;

   class deframe_tracker;
      logic [31:0]         max_length;
      cmdf_pkg::phase_type phase      [16];
      logic [2:0]          hdr_count  [16];
      logic [31:0]         length_acc [16];
      logic [15:0]         type_acc   [16];
      logic [31:0]         bytes_left [16];
      cmdf_pkg::rsp_type   pending_results [$];
      int                  errors;

      function new();
         max_length = cmdf_pkg::RESET_MAX_LENGTH;
         errors = 0;
         for (int s = 0; s < 16; s++) restart(s);
      endfunction

      function void restart(int s);
         phase[s]      = cmdf_pkg::PH_HEADER;
         hdr_count[s]  = 3'd0;
         length_acc[s] = 32'd0;
         type_acc[s]   = 16'd0;
         bytes_left[s] = 32'd0;
      endfunction

      function void expect_result(cmdf_pkg::rsp_type r);
         pending_results.insert(pending_results.size(), r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void accept_byte(logic [3:0] s, logic [7:0] b, logic ce);
         cmdf_pkg::rsp_type r;
         logic [2:0]        cnt;
         r = '0;
         r.out_session = s;
         if (phase[s] == cmdf_pkg::PH_DISCARD) begin
            if (ce) restart(s);
            return;
         end
         if (phase[s] == cmdf_pkg::PH_PAYLOAD) begin
            r.msg_code     = type_acc[s];
            r.payload_byte = b;
            r.has_data     = 1'b1;
            r.first        = (bytes_left[s] == length_acc[s] - cmdf_pkg::MIN_LENGTH);
            r.last         = (bytes_left[s] <= 32'd1);
            expect_result(r);
            if (r.last) restart(s);
            else bytes_left[s]--;
            return;
         end
         cnt = (hdr_count[s] >= cmdf_pkg::HDR_BYTES) ? 3'd0 : hdr_count[s];
         if (cnt < 3'd4) length_acc[s] |= 32'(b) << (8 * cnt);
         else type_acc[s] |= 16'(b) << (8 * (cnt - 4));
         cnt++;
         hdr_count[s] = cnt;
         if (cnt < cmdf_pkg::HDR_BYTES) return;
         r.msg_code = type_acc[s];
         if (length_acc[s] < cmdf_pkg::MIN_LENGTH || length_acc[s] > max_length) begin
            r.error = 1'b1;
            expect_result(r);
            restart(s);
            if (!ce) phase[s] = cmdf_pkg::PH_DISCARD;
         end else if (length_acc[s] == cmdf_pkg::MIN_LENGTH) begin
            r.first = 1'b1;
            r.last  = 1'b1;
            expect_result(r);
            restart(s);
         end else begin
            bytes_left[s] = length_acc[s] - cmdf_pkg::MIN_LENGTH;
            phase[s] = cmdf_pkg::PH_PAYLOAD;
         end
      endfunction

      function void check_result(cmdf_pkg::rsp_type got);
         cmdf_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            $error("result with nothing expected: session %0d type 0x%0h",
                   got.out_session, got.msg_code);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("out_session", want.out_session, got.out_session);
         compare_field("msg_code", want.msg_code, got.msg_code);
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
         compare_field("has_data", want.has_data, got.has_data);
         compare_field("first", want.first, got.first);
         compare_field("last", want.last, got.last);
         compare_field("error", want.error, got.error);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [3:0]  req_session;
   logic [7:0]  req_data_byte;
   logic        req_chunk_end;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_out_session;
   logic [15:0] rsp_msg_code;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_has_data;
   logic        rsp_first;
   logic        rsp_last;
   logic        rsp_error;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   deframe_tracker tracker;
   bit             no_idle = 1'b0;
   logic [7:0]     hdr_plan [16][6];

   control_message_deframer_core u_dut (.*);

   always #2 clock = ~clock;

   task automatic send_byte(input logic [3:0] s, input logic [7:0] b, input logic ce);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_session   <= s;
      req_data_byte <= b;
      req_chunk_end <= ce;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.accept_byte(s, b, ce);
      @(negedge clock);
   endtask

   task automatic send_header(input logic [3:0] s, input logic [31:0] len,
                              input logic [15:0] typ, input logic [5:0] ce_mask);
      logic [47:0] hdr;
      hdr = {typ, len};
      for (int k = 0; k < 6; k++) send_byte(s, hdr[8*k +: 8], ce_mask[k]);
   endtask

   // next byte of a session's stream, chosen from its tracked state
   task automatic send_next(input logic [3:0] s);
      logic [31:0] len;
      logic [31:0] cap;
      logic [31:0] lim;
      logic [31:0] ok_len;
      logic [15:0] typ;
      logic [2:0]  cnt;
      logic [7:0]  b;
      logic        ce;
      b  = 8'($urandom_range(0, 255));
      ce = ($urandom_range(0, 7) == 0);
      if (tracker.phase[s] == cmdf_pkg::PH_DISCARD) begin
         ce = ($urandom_range(0, 3) == 0);
      end else if (tracker.phase[s] == cmdf_pkg::PH_HEADER) begin
         cnt = tracker.hdr_count[s];
         if (cnt == 3'd0) begin
            cap = tracker.max_length;
            lim = (cap < 32'd20) ? cap : 32'd20;
            ok_len = (lim < 32'd3) ? cmdf_pkg::MIN_LENGTH : 32'($urandom_range(3, lim));
            case ($urandom_range(0, 9))
               0: len = cmdf_pkg::MIN_LENGTH;
               1: len = (cap >= 32'd3) ? 32'd3 : cmdf_pkg::MIN_LENGTH;
               2, 3, 4: len = ok_len;
               5: len = (cap <= 32'd40) ? cap : cmdf_pkg::MIN_LENGTH;
               6: len = 32'($urandom_range(0, 1));
               default: begin
                  if (cap == 32'hFFFF_FFFF) len = ok_len;
                  else case ($urandom_range(0, 2))
                     0: len = cap + 32'd1;
                     1: len = 32'hFFFF_FFFF;
                     default: len = 32'($urandom_range(32'hFFFF_FFFF, cap + 32'd1));
                  endcase
               end
            endcase
            case ($urandom_range(0, 3))
               0: typ = 16'h0000;
               1: typ = 16'hFFFF;
               default: typ = 16'($urandom_range(0, 16'hFFFF));
            endcase
            for (int k = 0; k < 4; k++) hdr_plan[s][k] = len[8*k +: 8];
            hdr_plan[s][4] = typ[7:0];
            hdr_plan[s][5] = typ[15:8];
         end
         b = hdr_plan[s][cnt];
         if (cnt == 3'd5) ce = ($urandom_range(0, 2) == 0);
      end
      send_byte(s, b, ce);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_max_length(input logic [31:0] v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {cmdf_pkg::REG_MAX_LENGTH, 2'b00};
      pwdata  <= v;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      tracker.max_length = v;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      tracker.compare_field("max_length", v, prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // result side: random stalls, in-order check
   initial begin
      int                hold;
      cmdf_pkg::rsp_type got;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 8);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.out_session  = rsp_out_session;
         got.msg_code     = rsp_msg_code;
         got.payload_byte = rsp_payload_byte;
         got.has_data     = rsp_has_data;
         got.first        = rsp_first;
         got.last         = rsp_last;
         got.error        = rsp_error;
         tracker.check_result(got);
         @(negedge clock);
      end
   end

   initial begin
      logic [3:0]  cur;
      logic [31:0] limits [6];
      tracker       = new();
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_session   = 4'd0;
      req_data_byte = 8'd0;
      req_chunk_end = 1'b0;
      rsp_stall     = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = 3'd0;
      pwdata        = 32'd0;
      cur           = 4'd0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty payload, chunk end inside a header
      send_header(4'd0, cmdf_pkg::MIN_LENGTH, 16'hFFFF, 6'b000100);
      // single-byte payload
      send_header(4'd15, 32'd3, 16'h0000, 6'b000000);
      send_byte(4'd15, 8'hFF, 1'b1);
      // rejected header whose last byte ends the chunk
      send_header(4'd5, 32'd0, 16'h1234, 6'b100000);
      // rejected header, then dropped bytes up to the chunk end
      send_header(4'd5, 32'hFFFF_FFFF, 16'hA5C3, 6'b000000);
      send_byte(4'd5, 8'h00, 1'b0);
      send_byte(4'd5, 8'h7F, 1'b1);

      limits[0] = cmdf_pkg::MIN_LENGTH;
      limits[1] = 32'hFFFF_FFFF;
      limits[2] = 32'($urandom_range(3, 40));
      limits[3] = cmdf_pkg::RESET_MAX_LENGTH;
      limits[4] = 32'd7;
      limits[5] = 32'h7FFF_FFFF;
      for (int p = 0; p < 6; p++) begin
         wait_idle();
         write_max_length(limits[p]);
         no_idle = (p % 3 == 2);
         for (int n = 0; n < 170; n++) begin
            if ($urandom_range(0, 1)) cur = 4'($urandom_range(0, 15));
            send_next(cur);
         end
         for (int s = 0; s < 16; s++)
            while (!(tracker.phase[s] == cmdf_pkg::PH_HEADER &&
                     tracker.hdr_count[s] == 3'd0))
               send_next(4'(s));
      end

      no_idle = 1'b0;
      wait_idle();
      repeat (10) @(negedge clock);
      if (tracker.errors == 0) begin
         $display("** control_message_deframer_core: PASSED **");
      end else begin
         $display("** control_message_deframer_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** control_message_deframer_core: FAILED **");
      $finish;
   end

endmodule

[filelist.f]
hdl/cmdf_pkg.sv
hdl/cmdf_ram.sv
hdl/cmdf_csr.sv
hdl/cmdf_ctx_update.sv
hdl/control_message_deframer_core.sv
dv/tb_top.sv
